FILE: rtl/dhcb_pkg.sv
// dhcb_pkg: shared constants, request codes and controller/datapath interface types
// for the d-ary huffman code builder; used by every module of the block
package dhcb_pkg;

   localparam int ALPHABET   = 256;
   localparam int SYM_BITS   = 8;
   localparam int COUNT_BITS = 32;
   localparam int NODE_DEPTH = 512;
   localparam int NODE_BITS  = 9;
   localparam int CNT_BITS   = NODE_BITS + 1;
   localparam int FREQ_BITS  = 47;
   localparam int NODE_W     = FREQ_BITS + 1;
   localparam int CODE_BITS  = 64;
   localparam int LEN_BITS   = 8;
   localparam int ARITY_BITS = 5;
   localparam int DIGIT_BITS = 4;
   localparam int LINK_W     = NODE_BITS + DIGIT_BITS;
   localparam int MIN_ARITY  = 2;
   localparam int MAX_ARITY  = 16;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   typedef enum logic [1:0] {
      FUNC_COUNT = 2'd0,
      FUNC_LAST  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef struct packed {
      logic accept;
      logic hist_clear;
      logic hist_inc;
      logic build_init;
      logic leaf_chk;
      logic tot_init;
      logic tot_step;
      logic pad_wr;
      logic live_init;
      logic merge_init;
      logic scan_init;
      logic scan_cmp;
      logic take;
      logic new_node;
      logic walk_init;
      logic walk_chk;
      logic link_up;
      logic code_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     hist_nz;
      logic     sym_last;
      logic     n_zero;
      logic     total_lt_n;
      logic     pad_done;
      logic     live_one;
      logic     scan_last;
      logic     pick_last;
      logic     at_root;
      logic     out_busy;
   } stat_type;

endpackage

FILE: rtl/dhcb_ctrl.sv
// dhcb_ctrl: sequencer for counting, clearing, tree build, code walk and queries
// depends on dhcb_pkg; drives dhcb_datapath through cmd_type and reads stat_type
module dhcb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  dhcb_pkg::func_type req_func,
   input  dhcb_pkg::stat_type stat,
   output logic              req_ready,
   output dhcb_pkg::cmd_type  cmd
);
   import dhcb_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001,
      S_HINC  = 20'h00002,
      S_BINIT = 20'h00004,
      S_LRD   = 20'h00008,
      S_LCHK  = 20'h00010,
      S_TOT0  = 20'h00020,
      S_TOT   = 20'h00040,
      S_PAD   = 20'h00080,
      S_MRG   = 20'h00100,
      S_SRD   = 20'h00200,
      S_SCMP  = 20'h00400,
      S_TAKE  = 20'h00800,
      S_NEW   = 20'h01000,
      S_WINIT = 20'h02000,
      S_WHRD  = 20'h04000,
      S_WHCHK = 20'h08000,
      S_WLRD  = 20'h10000,
      S_WLUP  = 20'h20000,
      S_WWR   = 20'h40000,
      S_QOUT  = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_func)
                  FUNC_CLEAR: cmd.hist_clear = 1'b1;
                  FUNC_QUERY: state_in = S_QOUT;
                  default:    state_in = S_HINC;
               endcase
            end
         end
         S_HINC: begin
            cmd.hist_inc = 1'b1;
            state_in = (stat.func == FUNC_LAST) ? S_BINIT : S_IDLE;
         end
         S_BINIT: begin
            cmd.build_init = 1'b1;
            state_in = S_LRD;
         end
         S_LRD: state_in = S_LCHK;
         S_LCHK: begin
            cmd.leaf_chk = 1'b1;
            state_in = stat.sym_last ? S_TOT0 : S_LRD;
         end
         S_TOT0: begin
            if (stat.n_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.tot_init = 1'b1;
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            if (stat.total_lt_n) cmd.tot_step = 1'b1;
            else state_in = S_PAD;
         end
         S_PAD: begin
            if (stat.pad_done) begin
               cmd.live_init = 1'b1;
               state_in = S_MRG;
            end else begin
               cmd.pad_wr = 1'b1;
            end
         end
         S_MRG: begin
            if (stat.live_one) begin
               state_in = S_WINIT;
            end else begin
               cmd.merge_init = 1'b1;
               cmd.scan_init  = 1'b1;
               state_in = S_SRD;
            end
         end
         S_SRD: state_in = S_SCMP;
         S_SCMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = stat.scan_last ? S_TAKE : S_SRD;
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            if (stat.pick_last) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_init = 1'b1;
               state_in = S_SRD;
            end
         end
         S_NEW: begin
            cmd.new_node = 1'b1;
            state_in = S_MRG;
         end
         S_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in = S_WHRD;
         end
         S_WHRD: state_in = S_WHCHK;
         S_WHCHK: begin
            cmd.walk_chk = 1'b1;
            if (stat.hist_nz) state_in = S_WLRD;
            else state_in = stat.sym_last ? S_IDLE : S_WHRD;
         end
         S_WLRD: state_in = stat.at_root ? S_WWR : S_WLUP;
         S_WLUP: begin
            cmd.link_up = 1'b1;
            state_in = S_WLRD;
         end
         S_WWR: begin
            cmd.code_wr = 1'b1;
            state_in = stat.sym_last ? S_IDLE : S_WHRD;
         end
         S_QOUT: begin
            if (!stat.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: rtl/dhcb_datapath.sv
// dhcb_datapath: histogram, node store, link store, code table and result register
// depends on dhcb_pkg; commanded by dhcb_ctrl
module dhcb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dhcb_pkg::cmd_type                      cmd,
   input  dhcb_pkg::func_type                     req_func,
   input  logic [dhcb_pkg::SYM_BITS-1:0]         req_byte,
   input  logic [dhcb_pkg::ARITY_BITS-1:0]       arity,
   input  logic                                  rsp_ready,
   output dhcb_pkg::stat_type                     stat,
   output logic                                  rsp_valid,
   output logic [dhcb_pkg::CODE_BITS-1:0]        rsp_code,
   output logic [dhcb_pkg::LEN_BITS-1:0]         rsp_len
);
   import dhcb_pkg::*;

   logic [COUNT_BITS-1:0]          hist_mem [ALPHABET];
   logic [ALPHABET-1:0]            hist_valid_ff;
   logic [COUNT_BITS-1:0]          hist_rd_ff;
   logic                           hv_ff;
   logic [NODE_W-1:0]              node_mem [NODE_DEPTH];
   logic [NODE_W-1:0]              node_rd_ff;
   logic [LINK_W-1:0]              link_mem [NODE_DEPTH];
   logic [LINK_W-1:0]              link_rd_ff;
   logic [CODE_BITS+LEN_BITS-1:0]  code_mem [ALPHABET];
   logic [ALPHABET-1:0]            code_valid_ff;
   logic [CODE_BITS+LEN_BITS-1:0]  code_rd_ff;
   logic                           cv_ff;

   func_type                       func_ff;
   logic [SYM_BITS-1:0]            byte_ff;
   logic [SYM_BITS-1:0]            sym_ff, sym_in;
   logic [CNT_BITS-1:0]            used_ff, used_in;
   logic [NODE_BITS-1:0]           n_ff, n_in;
   logic [NODE_BITS-1:0]           total_ff, total_in;
   logic [NODE_BITS-1:0]           live_ff, live_in;
   logic [CNT_BITS-1:0]            scan_ff, scan_in;
   logic [NODE_BITS-1:0]           best_ff, best_in;
   logic [FREQ_BITS-1:0]           bestf_ff, bestf_in;
   logic                           found_ff, found_in;
   logic [FREQ_BITS-1:0]           sum_ff, sum_in;
   logic [ARITY_BITS-1:0]          pick_ff, pick_in;
   logic [NODE_BITS-1:0]           node_ff, node_in;
   logic [NODE_BITS-1:0]           leaf_ff, leaf_in;
   logic [CODE_BITS-1:0]           code_ff, code_in;
   logic [LEN_BITS-1:0]            len_ff, len_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]           rsp_code_ff;
   logic [LEN_BITS-1:0]            rsp_len_ff;

   logic [SYM_BITS-1:0]            hist_addr;
   logic [COUNT_BITS-1:0]          hist_val;
   logic [COUNT_BITS-1:0]          hist_wdata;
   logic                           node_we;
   logic [NODE_BITS-1:0]           node_waddr;
   logic [NODE_W-1:0]              node_wdata;
   logic [ARITY_BITS-1:0]          d_m1;
   logic                           node_live;
   logic [FREQ_BITS-1:0]           node_freq;

   assign hist_addr  = cmd.accept ? req_byte : sym_ff;
   assign hist_val   = hv_ff ? hist_rd_ff : '0;
   assign hist_wdata = (&hist_val) ? hist_val : hist_val + COUNT_BITS'(1);
   assign d_m1       = arity - ARITY_BITS'(1);
   assign node_live  = node_rd_ff[NODE_W-1];
   assign node_freq  = node_rd_ff[FREQ_BITS-1:0];

   // histogram
   always_ff @(posedge clock) begin
      if (cmd.hist_inc) hist_mem[byte_ff] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_addr];
      hv_ff      <= hist_valid_ff[hist_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.hist_clear) hist_valid_ff <= '0;
      else if (cmd.hist_inc) hist_valid_ff[byte_ff] <= 1'b1;
   end

   // node store: live flag over frequency
   always_comb begin
      node_we    = 1'b0;
      node_waddr = used_ff[NODE_BITS-1:0];
      node_wdata = {1'b1, sum_ff};
      if (cmd.leaf_chk) begin
         node_we    = (hist_val != '0);
         node_wdata = {1'b1, FREQ_BITS'(hist_val)};
      end else if (cmd.pad_wr) begin
         node_we    = 1'b1;
         node_wdata = {1'b1, {FREQ_BITS{1'b0}}};
      end else if (cmd.take) begin
         node_we    = 1'b1;
         node_waddr = best_ff;
         node_wdata = {1'b0, bestf_ff};
      end else if (cmd.new_node) begin
         node_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rd_ff <= node_mem[scan_ff[NODE_BITS-1:0]];
   end

   // parent link and digit of every merged node
   always_ff @(posedge clock) begin
      if (cmd.take) link_mem[best_ff] <= {used_ff[NODE_BITS-1:0], pick_ff[DIGIT_BITS-1:0]};
      link_rd_ff <= link_mem[node_ff];
   end

   // code table
   always_ff @(posedge clock) begin
      if (cmd.code_wr) code_mem[sym_ff] <= {len_ff, code_ff};
      if (cmd.accept) begin
         code_rd_ff <= code_mem[req_byte];
         cv_ff      <= code_valid_ff[req_byte];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.build_init) code_valid_ff <= '0;
      else if (cmd.code_wr) code_valid_ff[sym_ff] <= 1'b1;
   end

   always_comb begin
      sym_in   = sym_ff;
      used_in  = used_ff;
      n_in     = n_ff;
      total_in = total_ff;
      live_in  = live_ff;
      scan_in  = scan_ff;
      best_in  = best_ff;
      bestf_in = bestf_ff;
      found_in = found_ff;
      sum_in   = sum_ff;
      pick_in  = pick_ff;
      node_in  = node_ff;
      leaf_in  = leaf_ff;
      code_in  = code_ff;
      len_in   = len_ff;
      if (cmd.build_init) begin
         sym_in  = '0;
         used_in = '0;
         n_in    = '0;
      end
      if (cmd.leaf_chk) begin
         sym_in = sym_ff + SYM_BITS'(1);
         if (hist_val != '0) begin
            used_in = used_ff + CNT_BITS'(1);
            n_in    = n_ff + NODE_BITS'(1);
         end
      end
      if (cmd.tot_init) total_in = NODE_BITS'(arity);
      if (cmd.tot_step) total_in = total_ff + NODE_BITS'(d_m1);
      if (cmd.pad_wr) used_in = used_ff + CNT_BITS'(1);
      if (cmd.live_init) live_in = total_ff;
      if (cmd.merge_init) begin
         sum_in  = '0;
         pick_in = '0;
      end
      if (cmd.scan_init) begin
         scan_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_cmp) begin
         scan_in = scan_ff + CNT_BITS'(1);
         if (node_live && (!found_ff || node_freq < bestf_ff)) begin
            found_in = 1'b1;
            best_in  = scan_ff[NODE_BITS-1:0];
            bestf_in = node_freq;
         end
      end
      if (cmd.take) begin
         sum_in  = sum_ff + bestf_ff;
         pick_in = pick_ff + ARITY_BITS'(1);
      end
      if (cmd.new_node) begin
         used_in = used_ff + CNT_BITS'(1);
         live_in = live_ff - NODE_BITS'(d_m1);
      end
      if (cmd.walk_init) begin
         sym_in  = '0;
         leaf_in = '0;
      end
      if (cmd.walk_chk) begin
         if (hist_val != '0) begin
            node_in = leaf_ff;
            leaf_in = leaf_ff + NODE_BITS'(1);
            code_in = '0;
            len_in  = '0;
         end else begin
            sym_in = sym_ff + SYM_BITS'(1);
         end
      end
      if (cmd.link_up) begin
         code_in = CODE_BITS'(code_ff * arity) + CODE_BITS'(link_rd_ff[DIGIT_BITS-1:0]);
         len_in  = len_ff + LEN_BITS'(1);
         node_in = link_rd_ff[LINK_W-1:DIGIT_BITS];
      end
      if (cmd.code_wr) sym_in = sym_ff + SYM_BITS'(1);
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      used_ff  <= used_in;
      n_ff     <= n_in;
      total_ff <= total_in;
      live_ff  <= live_in;
      scan_ff  <= scan_in;
      best_ff  <= best_in;
      bestf_ff <= bestf_in;
      found_ff <= found_in;
      sum_ff   <= sum_in;
      pick_ff  <= pick_in;
      node_ff  <= node_in;
      leaf_ff  <= leaf_in;
      code_ff  <= code_in;
      len_ff   <= len_in;
      if (cmd.accept) begin
         func_ff <= req_func;
         byte_ff <= req_byte;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (cmd.rsp_load) begin
         rsp_code_ff <= cv_ff ? code_rd_ff[CODE_BITS-1:0] : '0;
         rsp_len_ff  <= cv_ff ? code_rd_ff[CODE_BITS+LEN_BITS-1:CODE_BITS] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_len   = rsp_len_ff;

   assign stat.func       = func_ff;
   assign stat.hist_nz    = (hist_val != '0);
   assign stat.sym_last   = &sym_ff;
   assign stat.n_zero     = (n_ff == '0);
   assign stat.total_lt_n = (total_ff < n_ff);
   assign stat.pad_done   = (used_ff == CNT_BITS'(total_ff));
   assign stat.live_one   = (live_ff == NODE_BITS'(1));
   assign stat.scan_last  = (scan_ff + CNT_BITS'(1) == used_ff);
   assign stat.pick_last  = (pick_ff == d_m1);
   assign stat.at_root    = (CNT_BITS'(node_ff) == used_ff - CNT_BITS'(1));
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

FILE: rtl/dary_huffman_code_builder.sv
// Counts text bytes, builds a d-ary huffman code on the last byte and answers code queries.
// A clear request empties the histogram. A query waits while the result channel still
// holds an untaken result. After the last byte the build holds off new requests: it gathers
// the leaves, then for each node taken into a merge scans all nodes made so far through the
// node store, then walks over all 256 symbols, following the links of each occurring symbol
// digit by digit up to the root. Histogram and code table come out of reset cleared, with no
// clearing pass.
module dary_huffman_code_builder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // byte_value
   input  logic [1:0]                    req_tuser,   // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [71:0]                   rsp_tdata,   // code[63:0], code_len[71:64]
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dhcb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dhcb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dhcb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import dhcb_pkg::*;

   logic [ARITY_BITS-1:0] arity_ff, arity_in;
   logic [ARITY_BITS-1:0] wval;
   logic                  csr_we;
   cmd_type               cmd;
   stat_type              stat;
   logic [CODE_BITS-1:0]  rsp_code;
   logic [LEN_BITS-1:0]   rsp_len;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign wval       = csr_pwdata[ARITY_BITS-1:0];

   always_comb begin
      arity_in = arity_ff;
      if (csr_we) begin
         if (wval < ARITY_BITS'(MIN_ARITY)) arity_in = ARITY_BITS'(MIN_ARITY);
         else if (wval > ARITY_BITS'(MAX_ARITY)) arity_in = ARITY_BITS'(MAX_ARITY);
         else arity_in = wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) arity_ff <= ARITY_BITS'(MIN_ARITY);
      else arity_ff <= arity_in;
   end

   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DW'(arity_ff);

   dhcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (func_type'(req_tuser)),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   dhcb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_func  (func_type'(req_tuser)),
      .req_byte  (req_tdata),
      .arity     (arity_ff),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_code  (rsp_code),
      .rsp_len   (rsp_len)
   );

   assign rsp_tdata = {rsp_len, rsp_code};

endmodule
